### rtl/slseq_pkg.sv
// Shared types, constants and helper functions for the stair light sequencer.
package slseq_pkg;

   // Step array size, dim level offset and timing constants.
   localparam logic [4:0]  MAX_STEPS  = 5'd16;
   localparam logic [8:0]  DIM_OFFSET = 9'd60;
   localparam logic [15:0] FADE_TICKS = 16'd20;

   // Configuration register indexes.
   localparam logic [2:0] CSR_STEP_COUNT    = 3'd0;
   localparam logic [2:0] CSR_MIN_LEVEL     = 3'd1;
   localparam logic [2:0] CSR_MAX_LEVEL     = 3'd2;
   localparam logic [2:0] CSR_STEP_INTERVAL = 3'd3;
   localparam logic [2:0] CSR_HOLD_UP       = 3'd4;
   localparam logic [2:0] CSR_HOLD_DOWN     = 3'd5;
   localparam logic [2:0] CSR_ON_PATTERNS   = 3'd6;
   localparam logic [2:0] CSR_OFF_PATTERNS  = 3'd7;

   // On pattern codes.
   localparam logic [1:0] ON_CUMULATIVE = 2'd0;
   localparam logic [1:0] ON_CHASER     = 2'd1;
   localparam logic [1:0] ON_SWEEP      = 2'd2;
   localparam logic [1:0] ON_FADE       = 2'd3;

   // Off pattern codes.
   localparam logic [1:0] OFF_SEQ_OFF = 2'd0;
   localparam logic [1:0] OFF_SEQ_DIM = 2'd1;
   localparam logic [1:0] OFF_ALL_DIM = 2'd2;
   localparam logic [1:0] OFF_FADE    = 2'd3;

   // Sequence phases.
   typedef enum logic [1:0] {
      PH_IDLE,
      PH_ON,
      PH_HOLD,
      PH_OFF
   } phase_type;

   // Configuration register file.
   typedef struct packed {
      logic [4:0]  step_count;
      logic [7:0]  min_level;
      logic [7:0]  max_level;
      logic [15:0] step_interval_ms;
      logic [14:0] hold_up_ms;
      logic [14:0] hold_down_ms;
      logic [3:0]  on_patterns;
      logic [3:0]  off_patterns;
   } cfg_type;

   // Sensor levels carried by one tick.
   typedef struct packed {
      logic bottom_motion;
      logic top_motion;
      logic landing_motion;
      logic override_on;
   } sense_type;

   // One brightness command.
   typedef struct packed {
      logic       apply_all;
      logic [3:0] stair_index;
      logic [7:0] level;
      logic       last;
   } cmd_type;

   // Sequencer state.
   typedef struct packed {
      phase_type   phase;
      logic        going_up;
      logic [4:0]  position;
      logic [4:0]  sweep_count;
      logic [7:0]  fade_level;
      logic        fading_down;
      logic [15:0] wait_timer;
      logic        override_seen;
   } state_type;

   // Builds a command; a set-all command carries step index zero.
   function automatic cmd_type make_cmd(input logic all, input logic [3:0] idx,
                                        input logic [7:0] lvl);
      cmd_type c;
      c.apply_all   = all;
      c.stair_index = all ? 4'd0 : idx;
      c.level       = lvl;
      c.last        = 1'b0;
      return c;
   endfunction

   // Picks the up or down pattern field of a pattern register.
   function automatic logic [1:0] pick_pattern(input logic [3:0] pats, input logic up);
      return up ? pats[1:0] : pats[3:2];
   endfunction

endpackage

### rtl/stair_light_sequencer_core.sv
// Top level of the stair light sequencer: tick input register, registers, buffer.
//
//   Port group  Direction  Carries
//   req_*       in         one tick: sensor levels and override switch
//   rsp_*       out        brightness commands, up to two per tick
//   csr_*       in         register writes, index 0 to 7
//
// A tick with at most one command is taken every cycle while rsp_tready is high;
// after a tick with two commands, the next waits until the command buffer, which
// hands out one command per cycle while rsp_tready is high, has drained. Reset is
// synchronous: the sequencer goes idle and the registers return to their defaults.
// A stalled result side holds the pending commands; one further tick waits in the input register.
module stair_light_sequencer_core
   import slseq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Tick transaction.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // bottom_motion, top_motion, landing_motion, override_on, zeros
   // Command transaction.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // stair_index[3:0], level[11:4], zeros
   output logic        rsp_tuser,   // apply_all
   output logic        rsp_tlast,
   // Register writes.
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   logic       in_valid_ff, in_valid_in;
   sense_type  in_sense_ff, in_sense_in;
   cfg_type    cfg_ff, cfg_in;
   logic       space, fire, push;
   logic [1:0] cmd_count;
   cmd_type    cmd0, cmd1, out_cmd;

   // The held tick is consumed when the buffer can take all its commands.
   assign fire       = in_valid_ff && space;
   assign push       = fire && (cmd_count != 2'd0);
   assign req_tready = !in_valid_ff || fire;

   // Input register.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_sense_in = in_sense_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_sense_in.bottom_motion  = req_tdata[0];
         in_sense_in.top_motion     = req_tdata[1];
         in_sense_in.landing_motion = req_tdata[2];
         in_sense_in.override_on    = req_tdata[3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_sense_ff <= in_sense_in;
   end

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_STEP_COUNT:    cfg_in.step_count       = csr_wdata[4:0];
            CSR_MIN_LEVEL:     cfg_in.min_level        = csr_wdata[7:0];
            CSR_MAX_LEVEL:     cfg_in.max_level        = csr_wdata[7:0];
            CSR_STEP_INTERVAL: cfg_in.step_interval_ms = csr_wdata;
            CSR_HOLD_UP:       cfg_in.hold_up_ms       = csr_wdata[14:0];
            CSR_HOLD_DOWN:     cfg_in.hold_down_ms     = csr_wdata[14:0];
            CSR_ON_PATTERNS:   cfg_in.on_patterns      = csr_wdata[3:0];
            CSR_OFF_PATTERNS:  cfg_in.off_patterns     = csr_wdata[3:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{step_count: 5'd16, min_level: 8'd0, max_level: 8'd190,
                     step_interval_ms: 16'd400, hold_up_ms: 15'd10000,
                     hold_down_ms: 15'd5000, on_patterns: 4'd0, off_patterns: 4'd0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Sequencer.
   slseq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .sense     (in_sense_ff),
      .cfg       (cfg_ff),
      .cmd_count (cmd_count),
      .cmd0      (cmd0),
      .cmd1      (cmd1)
   );

   // Command buffer.
   slseq_cmd_buf u_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_count (cmd_count),
      .push_cmd0  (cmd0),
      .push_cmd1  (cmd1),
      .space      (space),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_cmd    (out_cmd)
   );

   // Result channel packing.
   assign rsp_tdata = {4'd0, out_cmd.level, out_cmd.stair_index};
   assign rsp_tuser = out_cmd.apply_all;
   assign rsp_tlast = out_cmd.last;

endmodule

### rtl/slseq_cmd_buf.sv
// Two-entry command buffer: drains a tick's commands one per cycle while out_ready is high.
module slseq_cmd_buf
   import slseq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  logic [1:0] push_count,
   input  cmd_type    push_cmd0,
   input  cmd_type    push_cmd1,
   output logic       space,
   output logic       out_valid,
   input  logic       out_ready,
   output cmd_type    out_cmd
);

   logic [1:0] count_ff, count_in;
   cmd_type    ent0_ff, ent0_in;
   cmd_type    ent1_ff, ent1_in;
   logic       pop;

   // Head of the buffer drives the result channel.
   assign out_valid = (count_ff != 2'd0);
   assign out_cmd   = ent0_ff;
   assign pop       = out_valid && out_ready;

   // Room for a whole tick once the buffer is empty after this cycle's pop.
   assign space = (count_ff == 2'd0) || ((count_ff == 2'd1) && pop);

   // Load both entries on a push, otherwise shift on a pop.
   always_comb begin
      count_in = count_ff;
      ent0_in  = ent0_ff;
      ent1_in  = ent1_ff;
      if (push) begin
         count_in = push_count;
         ent0_in  = push_cmd0;
         ent1_in  = push_cmd1;
      end else if (pop) begin
         count_in = count_ff - 2'd1;
         ent0_in  = ent1_ff;
      end
   end

   // Count register is control state; entries are payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      ent0_ff <= ent0_in;
      ent1_ff <= ent1_in;
   end

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("command buffer count out of range");
   a_pair_head_not_last: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2) |-> (!ent0_ff.last && ent1_ff.last))
      else $error("pair of commands has a misplaced last flag");
   a_push_needs_space: assert property (@(posedge clock) disable iff (reset)
      push |-> space) else $error("command push without room");
`endif

endmodule

### rtl/slseq_ctrl.sv
// Sequencer state register and the per-tick next-state and command logic.
module slseq_ctrl
   import slseq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  sense_type  sense,
   input  cfg_type    cfg,
   output logic [1:0] cmd_count,
   output cmd_type    cmd0,
   output cmd_type    cmd1
);

   state_type   state_ff, state_in;
   logic [4:0]  n_steps;
   logic [8:0]  dim_sum;
   logic [7:0]  dim_level;
   logic [15:0] interval;
   logic [15:0] timer_dec;
   cmd_type     emits [2];
   logic [1:0]  ecount;
   logic        run_on, run_off, run_hold, ok;
   logic [1:0]  pat;
   logic [14:0] hold_t;
   logic [4:0]  idx_diff;
   logic [3:0]  idx;

   // Live register values with their clamps applied.
   assign n_steps   = (cfg.step_count == 5'd0) ? 5'd1 :
                      (cfg.step_count > MAX_STEPS) ? MAX_STEPS : cfg.step_count;
   assign dim_sum   = {1'b0, cfg.min_level} + DIM_OFFSET;
   assign dim_level = dim_sum[8] ? 8'hFF : dim_sum[7:0];
   assign interval  = (cfg.step_interval_ms == 16'd0) ? 16'd1 : cfg.step_interval_ms;
   assign timer_dec = (state_ff.wait_timer != 16'd0) ? state_ff.wait_timer - 16'd1
                                                     : state_ff.wait_timer;

   // One tick of the sequencer: phase action, then on, hold and off steps.
   always_comb begin
      state_in  = state_ff;
      emits[0]  = '0;
      emits[1]  = '0;
      ecount    = 2'd0;
      run_on    = 1'b0;
      run_off   = 1'b0;
      run_hold  = 1'b0;
      ok        = 1'b0;
      pat       = 2'd0;
      hold_t    = 15'd0;
      idx_diff  = 5'd0;
      idx       = 4'd0;

      unique case (state_ff.phase)
         PH_IDLE: begin
            if (sense.override_on) begin
               state_in.override_seen = 1'b1;
               emits[ecount[0]] = make_cmd(1'b1, 4'd0, cfg.max_level);
               ecount = ecount + 2'd1;
            end else if (state_ff.override_seen) begin
               state_in.override_seen = 1'b0;
               emits[ecount[0]] = make_cmd(1'b1, 4'd0, cfg.min_level);
               ecount = ecount + 2'd1;
            end else if (sense.bottom_motion || sense.top_motion) begin
               state_in.going_up    = sense.bottom_motion;
               state_in.phase       = PH_ON;
               state_in.position    = 5'd0;
               state_in.sweep_count = 5'd0;
               state_in.fade_level  = cfg.min_level;
               state_in.fading_down = 1'b0;
               run_on = 1'b1;
            end
         end
         PH_ON: begin
            state_in.wait_timer = timer_dec;
            if (timer_dec == 16'd0) begin
               pat = pick_pattern(cfg.on_patterns, state_ff.going_up);
               if (pat == ON_FADE) begin
                  state_in.fade_level = state_ff.fade_level + 8'd1;
               end else begin
                  state_in.position = state_ff.position + 5'd1;
                  if (pat == ON_SWEEP && state_in.position >= n_steps) begin
                     state_in.position    = 5'd0;
                     state_in.sweep_count = state_ff.sweep_count + 5'd1;
                  end
               end
               run_on = 1'b1;
            end
         end
         PH_HOLD: begin
            state_in.wait_timer = timer_dec;
            if (timer_dec == 16'd0) begin
               if (sense.bottom_motion || sense.top_motion || sense.landing_motion) begin
                  run_hold = 1'b1;
               end else begin
                  state_in.phase       = PH_OFF;
                  state_in.position    = 5'd0;
                  state_in.sweep_count = 5'd0;
                  state_in.fade_level  = cfg.min_level;
                  state_in.fading_down = 1'b0;
                  run_off = 1'b1;
               end
            end
         end
         PH_OFF: begin
            state_in.wait_timer = timer_dec;
            if (timer_dec == 16'd0) begin
               pat = pick_pattern(cfg.off_patterns, state_ff.going_up);
               if (pat == OFF_FADE) begin
                  if (state_ff.fading_down) begin
                     if (state_ff.fade_level != 8'd0) begin
                        state_in.fade_level = state_ff.fade_level - 8'd1;
                     end
                  end else begin
                     state_in.fade_level = state_ff.fade_level + 8'd1;
                  end
               end else begin
                  state_in.position = state_ff.position + 5'd1;
               end
               run_off = 1'b1;
            end
         end
         default: begin
            state_in.phase = PH_IDLE;
         end
      endcase

      // Step index addressed at the current position.
      idx_diff = n_steps - 5'd1 - state_in.position;
      idx      = state_in.going_up ? state_in.position[3:0] : idx_diff[3:0];

      // On action; an exhausted on pattern moves to the hold.
      if (run_on) begin
         pat = pick_pattern(cfg.on_patterns, state_in.going_up);
         if (pat == ON_FADE) begin
            if (state_in.fade_level < cfg.max_level) begin
               emits[ecount[0]] = make_cmd(1'b1, 4'd0, state_in.fade_level);
               ecount = ecount + 2'd1;
               state_in.wait_timer = FADE_TICKS;
               ok = 1'b1;
            end
         end else if (state_in.position < n_steps &&
                      !(pat == ON_SWEEP && state_in.sweep_count >= n_steps)) begin
            if (pat != ON_CUMULATIVE) begin
               emits[ecount[0]] = make_cmd(1'b1, 4'd0, dim_level);
               ecount = ecount + 2'd1;
            end
            emits[ecount[0]] = make_cmd(1'b0, idx, cfg.max_level);
            ecount = ecount + 2'd1;
            state_in.wait_timer = interval;
            ok = 1'b1;
         end
         if (!ok) begin
            run_hold = 1'b1;
         end
      end

      // Hold entry or renewal.
      if (run_hold) begin
         hold_t = state_in.going_up ? cfg.hold_up_ms : cfg.hold_down_ms;
         state_in.phase      = PH_HOLD;
         state_in.wait_timer = (hold_t == 15'd0) ? 16'd1 : {1'b0, hold_t};
      end

      // Off action; an exhausted off pattern finishes with all steps at min.
      if (run_off) begin
         pat = pick_pattern(cfg.off_patterns, state_in.going_up);
         case (pat)
            OFF_ALL_DIM: begin
               emits[ecount[0]] = make_cmd(1'b1, 4'd0, dim_level);
               ecount = ecount + 2'd1;
            end
            OFF_FADE: begin
               if (!state_in.fading_down) begin
                  if (state_in.fade_level < cfg.max_level) begin
                     emits[ecount[0]] = make_cmd(1'b1, 4'd0, state_in.fade_level);
                     ecount = ecount + 2'd1;
                     state_in.wait_timer = FADE_TICKS;
                     ok = 1'b1;
                  end else begin
                     state_in.fading_down = 1'b1;
                     state_in.fade_level  = cfg.max_level;
                  end
               end
               if (!ok && state_in.fade_level > cfg.min_level) begin
                  emits[ecount[0]] = make_cmd(1'b1, 4'd0, state_in.fade_level);
                  ecount = ecount + 2'd1;
                  state_in.wait_timer = FADE_TICKS;
                  ok = 1'b1;
               end
            end
            default: begin
               if (state_in.position < n_steps) begin
                  emits[ecount[0]] = make_cmd(1'b0, idx,
                                              (pat == OFF_SEQ_OFF) ? 8'd0 : dim_level);
                  ecount = ecount + 2'd1;
                  state_in.wait_timer = interval;
                  ok = 1'b1;
               end
            end
         endcase
         if (!ok) begin
            emits[ecount[0]] = make_cmd(1'b1, 4'd0, cfg.min_level);
            ecount = ecount + 2'd1;
            state_in.phase      = PH_IDLE;
            state_in.wait_timer = 16'd0;
         end
      end
   end

   // Mark the final command of the tick.
   always_comb begin
      cmd_count = ecount;
      cmd0      = emits[0];
      cmd1      = emits[1];
      cmd0.last = (ecount == 2'd1);
      cmd1.last = 1'b1;
   end

   // State advances once per consumed tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{phase: PH_IDLE, default: '0};
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   a_idle_timer_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_IDLE) |-> (state_ff.wait_timer == 16'd0))
      else $error("wait timer running while idle");
   a_position_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff.position <= MAX_STEPS) && (state_ff.sweep_count <= MAX_STEPS))
      else $error("step cursor beyond the step array");
   a_active_timer_set: assert property (@(posedge clock) disable iff (reset)
      (fire && state_in.phase != PH_IDLE && state_ff.phase != PH_IDLE) |=>
      (state_ff.wait_timer != 16'd0))
      else $error("active phase left with an expired timer");
`endif

endmodule
